// File: rtl/poc_pkg.sv
`timescale 1ns / 1ps
package poc_pkg;

	localparam int DW = 32;
	localparam int EW = 48;
	localparam int FB = 16;

	localparam logic signed [EW-1:0] ELIM = {1'b0, {(EW-1){1'b1}}};
	localparam logic signed [EW-1:0] DLIM = {{(EW-DW+1){1'b0}}, {(DW-1){1'b1}}};

	typedef enum logic [2:0] {
		REG_MODE       = 3'd0,
		REG_PERIOD     = 3'd1,
		REG_MAX_VEL    = 3'd2,
		REG_DEAD_ZONE  = 3'd3,
		REG_FORCE_THR  = 3'd4,
		REG_INT_GAIN   = 3'd5,
		REG_DELTA_OFS  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_NONE     = 2'd0,
		MODE_ORIGINAL = 2'd1,
		MODE_DELTA    = 2'd2,
		MODE_SPARE    = 2'd3
	} ctrl_mode_t;

	localparam logic [1:0]  RST_MODE      = MODE_ORIGINAL;
	localparam logic [16:0] RST_PERIOD    = 17'd66;
	localparam logic [30:0] RST_MAX_VEL   = 31'd65536;
	localparam logic [30:0] RST_DEAD_ZONE = 31'd0;
	localparam logic [30:0] RST_FORCE_THR = 31'd0;
	localparam logic [16:0] RST_INT_GAIN  = 17'd6554;
	localparam logic [30:0] RST_DELTA_OFS = 31'd655;

	function automatic logic [EW-1:0] mag48(input logic signed [EW-1:0] x);
		mag48 = x[EW-1] ? (~x + 1'b1) : x;
	endfunction

	function automatic logic signed [EW-1:0] sat_e(input logic signed [EW+1:0] x);
		logic signed [EW+1:0] hi;
		logic signed [EW+1:0] lo;
		hi = {{2{1'b0}}, ELIM};
		lo = ~hi;
		if (x > hi)
			sat_e = ELIM;
		else if (x < lo)
			sat_e = ~ELIM;
		else
			sat_e = x[EW-1:0];
	endfunction

	function automatic logic signed [DW-1:0] sat_d(input logic signed [DW:0] x);
		logic signed [DW:0] hi;
		logic signed [DW:0] lo;
		hi = {2'b00, {(DW-1){1'b1}}};
		lo = ~hi;
		if (x > hi)
			sat_d = hi[DW-1:0];
		else if (x < lo)
			sat_d = lo[DW-1:0];
		else
			sat_d = x[DW-1:0];
	endfunction

endpackage

// File: rtl/poc_ifs.sv
`timescale 1ns / 1ps
interface poc_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] force_local;
	logic [31:0] velocity_local;
	logic [31:0] force_remote;
	logic [31:0] velocity_remote;
	logic [47:0] energy_remote;
	modport source (output valid, force_local, velocity_local, force_remote,
		velocity_remote, energy_remote, input ready);
	modport sink (input valid, force_local, velocity_local, force_remote,
		velocity_remote, energy_remote, output ready);
endinterface

interface poc_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] drive_command;
	logic [46:0] energy_in_to_send;
	modport source (output valid, drive_command, energy_in_to_send, input ready);
	modport sink (input valid, drive_command, energy_in_to_send, output ready);
endinterface

interface poc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/poc_mul.sv
`timescale 1ns / 1ps
// shift-add multiplier, floor(a*b / 2^FB) saturated to ELIM
module poc_mul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [poc_pkg::EW-1:0]  a,
	input  logic signed [poc_pkg::EW-1:0]  b,
	output logic                           done,
	output logic signed [poc_pkg::EW-1:0]  y
);
	localparam int EW = poc_pkg::EW;
	localparam int FB = poc_pkg::FB;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic          neg_q;
	logic [EW-1:0] ma_q;
	logic [EW-1:0] hi_q;
	logic [EW-1:0] lo_q;
	logic [EW:0]   sum;
	logic [2*EW-FB:0] q;
	logic [2*EW-FB:0] cap;
	logic [2*EW-FB:0] qc;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, ma_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(EW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= poc_pkg::mag48(a);
			lo_q  <= poc_pkg::mag48(b);
			hi_q  <= '0;
			neg_q <= a[EW-1] ^ b[EW-1];
		end else if (busy_q) begin
			hi_q <= sum[EW:1];
			lo_q <= {sum[0], lo_q[EW-1:1]};
		end
	end

	always_comb begin
		q   = {1'b0, hi_q, lo_q[EW-1:FB]} + (2*EW-FB+1)'(neg_q && (lo_q[FB-1:0] != '0));
		cap = (2*EW-FB+1)'(poc_pkg::ELIM) + (2*EW-FB+1)'(neg_q);
		qc  = (q > cap) ? cap : q;
		y   = neg_q ? -qc[EW-1:0] : qc[EW-1:0];
	end

	assign done = done_q;
endmodule

// File: rtl/poc_div.sv
`timescale 1ns / 1ps
// restoring divider, trunc(num * 2^FB / den) saturated to ELIM or DLIM
module poc_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           lim_e,
	input  logic signed [poc_pkg::EW-1:0]  num,
	input  logic signed [poc_pkg::EW-1:0]  den,
	output logic                           done,
	output logic signed [poc_pkg::EW-1:0]  y
);
	localparam int EW = poc_pkg::EW;
	localparam int FB = poc_pkg::FB;

	logic          busy_q;
	logic          done_q;
	logic [5:0]    cnt_q;
	logic          neg_q;
	logic          zero_q;
	logic          ovf_q;
	logic          lim_e_q;
	logic [EW-1:0] ud_q;
	logic [EW-1:0] rem_q;
	logic [EW-1:0] sh_q;
	logic [EW-1:0] quo_q;
	logic [EW-1:0] un;
	logic [EW-1:0] ud;
	logic          ovf;
	logic [EW:0]   trial;
	logic          fits;
	logic [EW-1:0] qq;
	logic [EW-1:0] cap;
	logic [EW-1:0] qc;

	assign un    = poc_pkg::mag48(num);
	assign ud    = poc_pkg::mag48(den);
	assign ovf   = {{(EW-FB){1'b0}}, un[EW-1:EW-FB]} >= ud;
	assign trial = {rem_q, sh_q[EW-1]};
	assign fits  = trial >= {1'b0, ud_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (num == '0 || ovf)
					done_q <= 1'b1;
				else
					busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'(EW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= num[EW-1] ^ den[EW-1];
			zero_q  <= (num == '0);
			ovf_q   <= ovf;
			lim_e_q <= lim_e;
			ud_q    <= ud;
			rem_q   <= {{(EW-FB){1'b0}}, un[EW-1:EW-FB]};
			sh_q    <= {un[EW-FB-1:0], {FB{1'b0}}};
			quo_q   <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? EW'(trial - {1'b0, ud_q}) : trial[EW-1:0];
			sh_q  <= {sh_q[EW-2:0], 1'b0};
			quo_q <= {quo_q[EW-2:0], fits};
		end
	end

	always_comb begin
		qq  = ovf_q ? '1 : quo_q;
		cap = (lim_e_q ? poc_pkg::ELIM : poc_pkg::DLIM) + EW'(neg_q);
		qc  = (qq > cap) ? cap : qq;
		y   = zero_q ? '0 : (neg_q ? -qc : qc);
	end

	assign done = done_q;
endmodule

// File: rtl/passivity_observer_controller_top.sv
`timescale 1ns / 1ps
// Passivity observer and controller for one teleoperation port.
// sample (sink): force_local, velocity_local, force_remote, velocity_remote,
//   energy_remote; one transfer per control sample.
// result (source): drive_command and energy_in_to_send, one per sample.
// cfg (sink): register index and data, always ready; write only while idle.
// One sample is worked by a small sequencer over a shared shift-add
// multiplier and a restoring divider: four multiplies in every mode,
// one more multiply and a divide for an original-mode update, two divides and
// two multiplies for a delta-mode update. A divide of zero or an overflowing
// divide finishes without iterating. sample.ready is high only while the
// sequencer is idle, so a new sample is not taken before the last one has
// been worked through. The result sits in an output register; the next sample
// is taken while it waits, and the sequencer holds its finished result until
// that register frees up if the receiver stalls.
// Reset clears all energy accumulators and held terms and loads the register
// defaults (mode 1, T = 66, max velocity 1.0).
module passivity_observer_controller_top (
	input  logic          clk,
	input  logic          arst_n,
	poc_sample_if.sink    sample,
	poc_result_if.source  result,
	poc_cfg_if.sink       cfg
);
	localparam int EW = poc_pkg::EW;
	localparam int DW = poc_pkg::DW;

	typedef enum logic [3:0] {
		S_IDLE, S_P, S_INC, S_DIS1, S_DIS2, S_EXC, S_M1MUL, S_M1DIV,
		S_M2PW, S_M2HOLD, S_M2MUL1, S_M2MUL2, S_FIN, S_OUT
	} state_t;

	state_t state_q;
	logic   go_q;
	logic   div_op;

	logic [1:0]  mode_q;
	logic [16:0] period_q;
	logic [30:0] max_vel_q;
	logic [30:0] dead_zone_q;
	logic [30:0] force_thr_q;
	logic [16:0] int_gain_q;
	logic [30:0] delta_ofs_q;

	logic signed [DW-1:0] f_q, vl_q, fr_q, vr_q;
	logic signed [EW-1:0] er_q;

	logic signed [EW-1:0] eout_q, ein_q, dis_q, rmax_q, integ_q;
	logic signed [DW-1:0] hold_q, cp_q, fp_q;
	logic signed [EW-1:0] p_q, m_q, pw_q, excess_q;
	logic signed [DW-1:0] drive_q;

	logic                 out_valid_q;
	logic signed [DW-1:0] out_drive_q;
	logic [EW-2:0]        out_energy_q;

	logic                 mul_done, div_done;
	logic signed [EW-1:0] mul_a, mul_b, mul_y;
	logic signed [EW-1:0] div_num, div_den, div_y;
	logic                 div_lim_e;

	logic signed [EW-1:0] t_ext, f_ext, dz_ext;
	logic signed [EW-1:0] p_dz, er_eff, excess;
	logic signed [DW:0]   den_n, d_ext;
	logic signed [DW:0]   mv_ext, hold_ext, hold_cl;
	logic signed [DW-1:0] drive;
	logic                 ctrl_on;

	assign t_ext  = {{(EW-17){1'b0}}, (period_q == '0) ? 17'd1 : period_q};
	assign f_ext  = {{(EW-DW){f_q[DW-1]}}, f_q};
	assign dz_ext = {{(EW-31){1'b0}}, dead_zone_q};
	assign ctrl_on = (mode_q == poc_pkg::MODE_ORIGINAL) || (mode_q == poc_pkg::MODE_DELTA);
	assign div_op  = state_q inside {S_M1DIV, S_M2PW, S_M2HOLD};

	always_comb begin
		if (poc_pkg::mag48(mul_y) < dz_ext)
			p_dz = '0;
		else if (!mul_y[EW-1])
			p_dz = mul_y - dz_ext;
		else
			p_dz = mul_y + dz_ext;
		er_eff = (er_q < rmax_q) ? rmax_q : er_q;
		excess = poc_pkg::sat_e({{2{eout_q[EW-1]}}, eout_q} + {{2{dis_q[EW-1]}}, dis_q}
			- {{2{er_eff[EW-1]}}, er_eff});
		d_ext  = {2'b00, (delta_ofs_q == '0) ? 31'd1 : delta_ofs_q};
		den_n  = {f_q[DW-1], f_q} + (f_q[DW-1] ? -d_ext : d_ext);
		mv_ext = {2'b00, max_vel_q};
		hold_ext = {hold_q[DW-1], hold_q};
		if (hold_ext > mv_ext)
			hold_cl = mv_ext;
		else if (hold_ext < -mv_ext)
			hold_cl = -mv_ext;
		else
			hold_cl = hold_ext;
		drive = poc_pkg::sat_d({vr_q[DW-1], vr_q} - hold_cl);
		if (vr_q == '0)
			drive = '0;
		else if (!vr_q[DW-1] && drive[DW-1])
			drive = '0;
		else if (vr_q[DW-1] && !drive[DW-1] && drive != '0)
			drive = '0;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_P: begin
				mul_a = f_ext;
				mul_b = {{(EW-DW){vr_q[DW-1]}}, vr_q};
			end
			S_INC: begin
				mul_a = t_ext;
				mul_b = p_q;
			end
			S_DIS1: begin
				mul_a = {{(EW-DW){cp_q[DW-1]}}, cp_q};
				mul_b = {{(EW-DW){fp_q[DW-1]}}, fp_q};
			end
			S_DIS2: begin
				mul_a = t_ext;
				mul_b = m_q;
			end
			S_M1MUL: begin
				mul_a = t_ext;
				mul_b = f_ext;
			end
			S_M2MUL1: begin
				mul_a = {{(EW-DW){cp_q[DW-1]}}, cp_q};
				mul_b = {{(EW-DW){vl_q[DW-1]}}, vl_q};
			end
			S_M2MUL2: begin
				mul_a = {{(EW-17){1'b0}}, int_gain_q};
				mul_b = poc_pkg::sat_e({{2{pw_q[EW-1]}}, pw_q} - {{2{m_q[EW-1]}}, m_q});
			end
			default: ;
		endcase
	end

	always_comb begin
		div_num   = excess_q;
		div_den   = m_q;
		div_lim_e = 1'b0;
		case (state_q)
			S_M2PW: begin
				div_den   = t_ext;
				div_lim_e = 1'b1;
			end
			S_M2HOLD: begin
				div_num = poc_pkg::sat_e({{2{pw_q[EW-1]}}, pw_q} + {{2{integ_q[EW-1]}}, integ_q});
				div_den = {{(EW-DW-1){den_n[DW]}}, den_n};
			end
			default: ;
		endcase
	end

	poc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q && !div_op),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.y      (mul_y)
	);

	poc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_q && div_op),
		.lim_e  (div_lim_e),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.y      (div_y)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= poc_pkg::RST_MODE;
			period_q    <= poc_pkg::RST_PERIOD;
			max_vel_q   <= poc_pkg::RST_MAX_VEL;
			dead_zone_q <= poc_pkg::RST_DEAD_ZONE;
			force_thr_q <= poc_pkg::RST_FORCE_THR;
			int_gain_q  <= poc_pkg::RST_INT_GAIN;
			delta_ofs_q <= poc_pkg::RST_DELTA_OFS;
		end else if (cfg.valid) begin
			case (cfg.index)
				poc_pkg::REG_MODE:      mode_q      <= cfg.data[1:0];
				poc_pkg::REG_PERIOD:    period_q    <= cfg.data[16:0];
				poc_pkg::REG_MAX_VEL:   max_vel_q   <= cfg.data[30:0];
				poc_pkg::REG_DEAD_ZONE: dead_zone_q <= cfg.data[30:0];
				poc_pkg::REG_FORCE_THR: force_thr_q <= cfg.data[30:0];
				poc_pkg::REG_INT_GAIN:  int_gain_q  <= cfg.data[16:0];
				poc_pkg::REG_DELTA_OFS: delta_ofs_q <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			f_q  <= sample.force_local;
			vl_q <= sample.velocity_local;
			fr_q <= sample.force_remote;
			vr_q <= sample.velocity_remote;
			er_q <= sample.energy_remote;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			go_q         <= 1'b0;
			eout_q       <= '0;
			ein_q        <= '0;
			dis_q        <= '0;
			rmax_q       <= '0;
			integ_q      <= '0;
			hold_q       <= '0;
			cp_q         <= '0;
			fp_q         <= '0;
			out_valid_q  <= 1'b0;
			out_drive_q  <= '0;
			out_energy_q <= '0;
		end else begin
			go_q <= 1'b0;
			if (result.ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						state_q <= S_P;
						go_q    <= 1'b1;
					end
				end
				S_P: begin
					if (mul_done) begin
						p_q     <= p_dz;
						state_q <= S_INC;
						go_q    <= 1'b1;
					end
				end
				S_INC: begin
					if (mul_done) begin
						if (p_q[EW-1])
							ein_q <= poc_pkg::sat_e({{2{ein_q[EW-1]}}, ein_q}
								- {{2{mul_y[EW-1]}}, mul_y});
						else
							eout_q <= poc_pkg::sat_e({{2{eout_q[EW-1]}}, eout_q}
								+ {{2{mul_y[EW-1]}}, mul_y});
						state_q <= S_DIS1;
						go_q    <= 1'b1;
					end
				end
				S_DIS1: begin
					if (mul_done) begin
						m_q     <= mul_y;
						state_q <= S_DIS2;
						go_q    <= 1'b1;
					end
				end
				S_DIS2: begin
					if (mul_done) begin
						dis_q <= poc_pkg::sat_e({{2{dis_q[EW-1]}}, dis_q}
							- {{2{mul_y[EW-1]}}, mul_y});
						state_q <= S_EXC;
					end
				end
				S_EXC: begin
					rmax_q   <= er_eff;
					excess_q <= excess;
					state_q  <= S_FIN;
					if (mode_q == poc_pkg::MODE_ORIGINAL) begin
						if (!excess[EW-1] && excess != '0
							&& {1'b0, (f_q[DW-1] ? -f_q : f_q)} >= {2'b00, force_thr_q}) begin
							state_q <= S_M1MUL;
							go_q    <= 1'b1;
						end
					end else if (mode_q == poc_pkg::MODE_DELTA) begin
						if (!excess[EW-1] && excess != '0) begin
							state_q <= S_M2PW;
							go_q    <= 1'b1;
						end else begin
							integ_q <= '0;
						end
					end
				end
				S_M1MUL: begin
					if (mul_done) begin
						m_q     <= mul_y;
						state_q <= S_M1DIV;
						go_q    <= 1'b1;
					end
				end
				S_M1DIV: begin
					if (div_done) begin
						hold_q  <= div_y[DW-1:0];
						state_q <= S_FIN;
					end
				end
				S_M2PW: begin
					if (div_done) begin
						pw_q    <= div_y;
						state_q <= S_M2HOLD;
						go_q    <= 1'b1;
					end
				end
				S_M2HOLD: begin
					if (div_done) begin
						hold_q  <= div_y[DW-1:0];
						state_q <= S_M2MUL1;
						go_q    <= 1'b1;
					end
				end
				S_M2MUL1: begin
					if (mul_done) begin
						m_q     <= mul_y;
						state_q <= S_M2MUL2;
						go_q    <= 1'b1;
					end
				end
				S_M2MUL2: begin
					if (mul_done) begin
						integ_q <= poc_pkg::sat_e({{2{integ_q[EW-1]}}, integ_q}
							+ {{2{mul_y[EW-1]}}, mul_y});
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (ctrl_on) begin
						hold_q  <= hold_cl[DW-1:0];
						cp_q    <= hold_cl[DW-1:0];
						drive_q <= drive;
					end else begin
						cp_q    <= '0;
						drive_q <= fr_q;
					end
					fp_q    <= f_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q  <= 1'b1;
						out_drive_q  <= drive_q;
						out_energy_q <= ein_q[EW-1] ? '0 : ein_q[EW-2:0];
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample.ready            = (state_q == S_IDLE);
	assign result.valid            = out_valid_q;
	assign result.drive_command     = out_drive_q;
	assign result.energy_in_to_send = out_energy_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_done && div_done))
		else $error("multiplier and divider finished together");

	a_start_on_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> go_q && state_q == S_P)
		else $error("sample transfer did not start the sequencer");

	a_out_release: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT && (!out_valid_q || result.ready) |=> state_q == S_IDLE && out_valid_q)
		else $error("finished result not moved to output register");

	a_energy_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !ein_q[EW-1])
		else $error("incoming energy accumulator went negative");
endmodule
